/* src/crc16hx_pkg.sv */
// Shared types, codes and CRC helpers for the CRC-16 hex line frame checker.
// No dependencies.
`timescale 1ns / 1ps

package crc16hx_pkg;

    localparam int BYTE_W = 8;
    localparam int CRC_W = 16;
    localparam int LEN_W = 16;
    localparam int STATUS_W = 2;
    localparam int TAIL_LEN = 4;
    localparam int FILL_W = 3;
    localparam int TDATA_W = 32;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [BYTE_W-1:0] LINE_END = 8'h0A;
    localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;
    localparam logic [FILL_W-1:0] FILL_FULL = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GOOD  = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_BAD   = 2'd2
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             item_kind;
        logic [BYTE_W-1:0] payload_byte;
        status_t           frame_status;
        logic [LEN_W-1:0]  payload_length;
    } result_t;

    // Byte-wide reflected CRC-16 update, eight shift/xor steps.
    function automatic logic [CRC_W-1:0] crc_fold(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Uppercase ASCII hex digit for a nibble.
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] ch;
        if (nib < 4'd10)
            ch = 8'h30 + {4'h0, nib};
        else
            ch = 8'h37 + {4'h0, nib};
        return ch;
    endfunction

endpackage

/* src/crc16hx_in_stage.sv */
// Input register for received line bytes.
// Depends on crc16hx_pkg.
`timescale 1ns / 1ps

module crc16hx_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [crc16hx_pkg::BYTE_W-1:0] s_byte,
    output logic                            in_valid,
    output logic [crc16hx_pkg::BYTE_W-1:0] in_byte,
    input  logic                            take
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [crc16hx_pkg::BYTE_W-1:0] byte_reg;

    // Slot frees up when the core consumes the held byte this cycle.
    assign s_ready = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            byte_reg <= s_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte = byte_reg;

endmodule

/* src/crc16hx_frame_core.sv */
// Frame state: CRC accumulator, four-byte delay line, fill and payload count.
// Builds one result per consumed byte where one is due. Depends on crc16hx_pkg.
`timescale 1ns / 1ps

module crc16hx_frame_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [crc16hx_pkg::BYTE_W-1:0] in_byte,
    input  logic                            out_free,
    output logic                            take,
    output logic                            res_valid,
    output crc16hx_pkg::result_t            res
);

    logic [crc16hx_pkg::CRC_W-1:0]  crc_reg;
    logic [crc16hx_pkg::CRC_W-1:0]  crc_next;
    logic [crc16hx_pkg::FILL_W-1:0] fill_reg;
    logic [crc16hx_pkg::FILL_W-1:0] fill_next;
    logic [crc16hx_pkg::LEN_W-1:0]  count_reg;
    logic [crc16hx_pkg::LEN_W-1:0]  count_next;
    logic [crc16hx_pkg::BYTE_W-1:0] tail_reg [crc16hx_pkg::TAIL_LEN];

    logic is_end;
    logic is_full;
    logic produces;
    logic digits_ok;

    assign is_end = (in_byte == crc16hx_pkg::LINE_END);
    assign is_full = (fill_reg == crc16hx_pkg::FILL_FULL);
    assign produces = is_end || is_full;
    // A byte that only fills the delay line needs no output slot.
    assign take = in_valid && (!produces || out_free);
    assign res_valid = take && produces;

    // Oldest tail byte holds the most significant hex digit.
    assign digits_ok =
        (tail_reg[0] == crc16hx_pkg::hex_char(crc_reg[15:12])) &&
        (tail_reg[1] == crc16hx_pkg::hex_char(crc_reg[11:8])) &&
        (tail_reg[2] == crc16hx_pkg::hex_char(crc_reg[7:4])) &&
        (tail_reg[3] == crc16hx_pkg::hex_char(crc_reg[3:0]));

    always_comb
    begin
        crc_next = crc_reg;
        fill_next = fill_reg;
        count_next = count_reg;
        res.item_kind = crc16hx_pkg::KIND_PAYLOAD;
        res.payload_byte = tail_reg[0];
        res.frame_status = crc16hx_pkg::STATUS_GOOD;
        res.payload_length = count_reg;
        if (is_end)
        begin
            res.item_kind = crc16hx_pkg::KIND_STATUS;
            res.payload_byte = '0;
            if (!is_full)
                res.frame_status = crc16hx_pkg::STATUS_SHORT;
            else if (!digits_ok)
                res.frame_status = crc16hx_pkg::STATUS_BAD;
            crc_next = crc16hx_pkg::CRC_INIT;
            fill_next = '0;
            count_next = '0;
        end
        else if (is_full)
        begin
            crc_next = crc16hx_pkg::crc_fold(crc_reg, tail_reg[0]);
            if (count_reg != crc16hx_pkg::LEN_MAX)
                count_next = count_reg + 1'b1;
            res.payload_length = count_next;
        end
        else
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= crc16hx_pkg::CRC_INIT;
            fill_reg <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            crc_reg <= crc_next;
            fill_reg <= fill_next;
            count_reg <= count_next;
        end
    end

    // Delay line: fill in order, then shift once full.
    always_ff @(posedge clk)
    begin
        if (take && !is_end)
        begin
            if (is_full)
            begin
                for (int k = 0; k < crc16hx_pkg::TAIL_LEN - 1; k++)
                    tail_reg[k] <= tail_reg[k+1];
                tail_reg[crc16hx_pkg::TAIL_LEN-1] <= in_byte;
            end
            else
            begin
                tail_reg[fill_reg[1:0]] <= in_byte;
            end
        end
    end

endmodule

/* src/crc16hx_out_reg.sv */
// Result register driving the output stream.
// Depends on crc16hx_pkg.
`timescale 1ns / 1ps

module crc16hx_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    input  crc16hx_pkg::result_t                res,
    output logic                                out_free,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [crc16hx_pkg::TDATA_W-1:0]    m_data,
    output logic                                m_user
);

    logic                 valid_reg;
    logic                 valid_next;
    crc16hx_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign valid_next = res_valid || (valid_reg && !m_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_user = res_reg.item_kind;
    assign m_data = {6'd0, res_reg.payload_length, res_reg.frame_status,
                     res_reg.payload_byte};

endmodule

/* src/crc16_hex_line_frame_checker_unit.sv */
// Top level of the CRC-16 hex line frame checker.
// Depends on crc16hx_pkg, crc16hx_in_stage, crc16hx_frame_core, crc16hx_out_reg.
`timescale 1ns / 1ps

// Takes one received line byte per transfer and holds back the last four bytes
// of each line. Each byte pushed out of that four-byte window is emitted as a
// payload transfer (tuser 0) and folded into a CRC-16/MODBUS. A newline emits
// one status transfer (tuser 1): good when the held four bytes are the CRC in
// uppercase ASCII hex, most significant digit first; short when fewer than four
// bytes preceded the newline; bad otherwise. Bytes still filling the window
// give no output. One byte is taken every cycle while the output is not stalled;
// each byte is captured in the input register and its result is then loaded
// into the result register, with the byte-wide CRC update between the input
// register and the result register. Output stalls hold the pipeline.

module crc16_hex_line_frame_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [9:8] frame_status, [25:10] payload_length, rest zero
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tuser    // [0] item_kind
);

    logic                            in_valid;
    logic [crc16hx_pkg::BYTE_W-1:0] in_byte;
    logic                            take;
    logic                            out_free;
    logic                            res_valid;
    crc16hx_pkg::result_t            res;

    crc16hx_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_byte   (s_axis_tdata),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .take     (take)
    );

    crc16hx_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .out_free  (out_free),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    crc16hx_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_user    (m_axis_tuser)
    );

endmodule

/* verif/crc16_hex_line_frame_checker_unit_test.sv */
// Self-checking bench for crc16_hex_line_frame_checker_unit: stream-driven frames
// with predicted payload and status transfers. Depends on crc16hx_pkg and the unit.
`timescale 1ns / 1ps

module crc16_hex_line_frame_checker_unit_test;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_BYTES = 1050;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {
        TRAILER_GOOD,
        TRAILER_BAD_DIGIT,
        TRAILER_LOWER_HEX,
        TRAILER_NOISE
    } trailer_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic [7:0]           line_bytes[$];
    logic [7:0]           frame_body[$];
    crc16hx_pkg::result_t frame_results_due[$];

    // running copy of the checker state
    logic [crc16hx_pkg::CRC_W-1:0] shadow_crc;
    logic [7:0]                    shadow_tail [crc16hx_pkg::TAIL_LEN];
    int                            shadow_fill;
    logic [crc16hx_pkg::LEN_W-1:0] shadow_count;

    int bytes_total;
    int bytes_taken;
    int mismatch_count;
    int cycle_count;
    int burst_left;
    int gap_left;
    int ready_mode;
    int ready_left;

    crc16_hex_line_frame_checker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Bit-serial CRC-16/MODBUS, LSB of the data byte first.
    function automatic logic [crc16hx_pkg::CRC_W-1:0] crc16_modbus_update(
        input logic [crc16hx_pkg::CRC_W-1:0] crc,
        input logic [7:0]                    data
    );
        logic [crc16hx_pkg::CRC_W-1:0] c;
        logic                          fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c = c >> 1;
            if (fb)
                c = c ^ crc16hx_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic logic [7:0] ascii_hex_upper(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib > 4'd9)
            ch = "A" + {4'h0, nib} - 8'd10;
        else
            ch = "0" + {4'h0, nib};
        return ch;
    endfunction

    function automatic logic [7:0] random_content();
        int unsigned r;
        logic [7:0]  b;
        r = $urandom_range(0, 99);
        if (r < 10)
            b = 8'h00;
        else if (r < 20)
            b = 8'hFF;
        else
        begin
            b = crc16hx_pkg::LINE_END;
            while (b == crc16hx_pkg::LINE_END)
                b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    task automatic clear_shadow();
        shadow_crc = crc16hx_pkg::CRC_INIT;
        shadow_fill = 0;
        shadow_count = '0;
        for (int k = 0; k < crc16hx_pkg::TAIL_LEN; k++)
            shadow_tail[k] = 8'h00;
    endtask

    // Predict what one accepted line byte produces.
    task automatic fold_line_byte(input logic [7:0] rx);
        crc16hx_pkg::result_t r;
        crc16hx_pkg::status_t st;
        logic [7:0]           leaving;
        if (rx == crc16hx_pkg::LINE_END)
        begin
            if (shadow_fill < crc16hx_pkg::TAIL_LEN)
                st = crc16hx_pkg::STATUS_SHORT;
            else
            begin
                st = crc16hx_pkg::STATUS_GOOD;
                for (int k = 0; k < crc16hx_pkg::TAIL_LEN; k++)
                    if (shadow_tail[k] != ascii_hex_upper(shadow_crc[15 - 4*k -: 4]))
                        st = crc16hx_pkg::STATUS_BAD;
            end
            r.item_kind = crc16hx_pkg::KIND_STATUS;
            r.payload_byte = 8'h00;
            r.frame_status = st;
            r.payload_length = shadow_count;
            frame_results_due.push_back(r);
            clear_shadow();
        end
        else if (shadow_fill < crc16hx_pkg::TAIL_LEN)
        begin
            shadow_tail[shadow_fill] = rx;
            shadow_fill++;
        end
        else
        begin
            leaving = shadow_tail[0];
            shadow_crc = crc16_modbus_update(shadow_crc, leaving);
            if (shadow_count != crc16hx_pkg::LEN_MAX)
                shadow_count++;
            for (int k = 0; k + 1 < crc16hx_pkg::TAIL_LEN; k++)
                shadow_tail[k] = shadow_tail[k + 1];
            shadow_tail[crc16hx_pkg::TAIL_LEN - 1] = rx;
            r.item_kind = crc16hx_pkg::KIND_PAYLOAD;
            r.payload_byte = leaving;
            r.frame_status = crc16hx_pkg::STATUS_GOOD;
            r.payload_length = shadow_count;
            frame_results_due.push_back(r);
        end
    endtask

    // Queue frame_body, a four-character trailer and the newline; empties frame_body.
    task automatic queue_frame(input trailer_kind_t kind);
        logic [crc16hx_pkg::CRC_W-1:0] crc;
        logic [7:0]                    trailer [4];
        int                            pick;
        crc = crc16hx_pkg::CRC_INIT;
        foreach (frame_body[i])
        begin
            crc = crc16_modbus_update(crc, frame_body[i]);
            line_bytes.push_back(frame_body[i]);
        end
        frame_body.delete();
        for (int k = 0; k < 4; k++)
            trailer[k] = ascii_hex_upper(crc[15 - 4*k -: 4]);
        case (kind)
            TRAILER_BAD_DIGIT:
            begin
                pick = $urandom_range(0, 3);
                trailer[pick] = trailer[pick] ^ (8'h01 << $urandom_range(0, 7));
                if (trailer[pick] == crc16hx_pkg::LINE_END)
                    trailer[pick] = 8'h00;
            end
            TRAILER_LOWER_HEX:
                for (int k = 0; k < 4; k++)
                    if (trailer[k] >= "A" && trailer[k] <= "F")
                        trailer[k] = trailer[k] + 8'h20;
            TRAILER_NOISE:
                for (int k = 0; k < 4; k++)
                    trailer[k] = random_content();
            default: ;
        endcase
        for (int k = 0; k < 4; k++)
            line_bytes.push_back(trailer[k]);
        line_bytes.push_back(crc16hx_pkg::LINE_END);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Sender: bursts of random length separated by random gaps, some gapless.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                fold_line_byte(s_axis_tdata);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata <= 8'($urandom);
                end
                else if (line_bytes.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= line_bytes.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches between always ready, coin flip, rare stall and a pattern from ready_left bit 1.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_mode = 0;
            ready_left = 0;
        end
        else
        begin
            if (ready_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                ready_left = $urandom_range(8, 80);
            end
            else
                ready_left--;
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= ready_left[1];
            endcase
        end
    end

    // Monitor: each output transfer against the oldest predicted result.
    always @(posedge clk)
    begin
        crc16hx_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_results_due.size() == 0)
                report_mismatch("result with none due", m_axis_tdata, 0);
            else
            begin
                want = frame_results_due.pop_front();
                if (m_axis_tuser != want.item_kind)
                    report_mismatch("item_kind", m_axis_tuser, want.item_kind);
                if (m_axis_tdata[7:0] != want.payload_byte)
                    report_mismatch("payload_byte", m_axis_tdata[7:0], want.payload_byte);
                if (m_axis_tdata[9:8] != want.frame_status)
                    report_mismatch("frame_status", m_axis_tdata[9:8], want.frame_status);
                if (m_axis_tdata[25:10] != want.payload_length)
                    report_mismatch("payload_length", m_axis_tdata[25:10],
                                    want.payload_length);
                if (m_axis_tdata[31:26] != 6'd0)
                    report_mismatch("tdata padding", m_axis_tdata[31:26], 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned r;
        int          n;
        bytes_taken = 0;
        mismatch_count = 0;
        cycle_count = 0;
        clear_shadow();

        // directed: empty line, short lines, zero payload, extreme bytes, bad digit
        line_bytes.push_back(crc16hx_pkg::LINE_END);
        line_bytes.push_back("A");
        line_bytes.push_back("B");
        line_bytes.push_back(crc16hx_pkg::LINE_END);
        repeat (3) line_bytes.push_back("F");
        line_bytes.push_back(crc16hx_pkg::LINE_END);
        queue_frame(TRAILER_GOOD);
        frame_body = '{8'h00, 8'hFF};
        queue_frame(TRAILER_GOOD);
        frame_body = '{8'h80, 8'h01};
        queue_frame(TRAILER_BAD_DIGIT);

        while (line_bytes.size() < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    n = $urandom_range(0, 8);
                else if (r < 95)
                    n = $urandom_range(9, 64);
                else
                    n = $urandom_range(65, 400);
                repeat (n) frame_body.push_back(random_content());
                r = $urandom_range(0, 99);
                if (r < 65)
                    queue_frame(TRAILER_GOOD);
                else if (r < 80)
                    queue_frame(TRAILER_BAD_DIGIT);
                else if (r < 90)
                    queue_frame(TRAILER_LOWER_HEX);
                else
                    queue_frame(TRAILER_NOISE);
            end
            else if (r < 93)
            begin
                repeat ($urandom_range(0, 3)) line_bytes.push_back(random_content());
                line_bytes.push_back(crc16hx_pkg::LINE_END);
            end
            else
            begin
                // loose noise, newlines included
                repeat ($urandom_range(1, 8))
                    if ($urandom_range(0, 3) == 0)
                        line_bytes.push_back(crc16hx_pkg::LINE_END);
                    else
                        line_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        bytes_total = line_bytes.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < bytes_total)
            @(negedge clk);
        while (frame_results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (frame_results_due.size() != 0)
            report_mismatch("results never seen", frame_results_due.size(), 0);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
